FILE: rtl/fdr_pkg.sv
// Shared types and constants for the feeder roller sequencer.
// No dependencies; imported by every module of the block.
package fdr_pkg;

    // Field widths
    localparam int DRIVE_W = 16;
    localparam int WIN_W   = 20;
    localparam int COUNT_W = 16;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // 0.2 scale: (cmd * 13107) >>> 16
    localparam logic signed [31:0] FIFTH_MULT  = 32'sd13107;
    localparam int                 FIFTH_SHIFT = 16;

    // Register word indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SWITCH_PRESENT = 2'd0;
    localparam logic [1:0] REG_TRIGGER_WAIT   = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE_IN    = 2'd2;
    localparam logic [1:0] REG_DEBOUNCE_OUT   = 2'd3;

    // Sequencer phases
    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_STAGING = 2'd1,
        PH_FIRING  = 2'd2,
        PH_FIRED   = 2'd3
    } phase_t;

    // Configuration seen by the sequencer core
    typedef struct packed {
        logic               switch_present;
        logic [WIN_W-1:0]   trigger_wait_ticks;
        logic [WIN_W-1:0]   debounce_in_ticks;
        logic [WIN_W-1:0]   debounce_out_ticks;
    } cfg_t;

endpackage

FILE: rtl/feeder_roller_sequencer.sv
// Feeder roller sequencer, top level: input word register, sequencer core,
// result handshake. Depends on fdr_pkg, fdr_regs and fdr_core.
//
// One word in gives one word out. A word is accepted in every cycle while
// the result side keeps up. The accepting edge loads the input register;
// the core's state/result register is loaded when the core steps, which a
// result-side stall can hold off, and the result is presented from it. The
// sequencer state is the result register, so each word sees the state left
// by the previous one. Write the configuration registers only while no
// word is in flight. TIME_BITS sets the width of the two elapsed-tick
// counters; a window at least as large as the saturated counter makes a
// released switch keep reading pressed.
module feeder_roller_sequencer
    import fdr_pkg::*;
#(
    parameter int TIME_BITS = 20
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      switch_level,
    input  logic                      shooter_running,
    input  logic signed [DRIVE_W-1:0] drive_command,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DRIVE_W-1:0] motor_drive,
    output logic [1:0]                phase,
    output logic [COUNT_W-1:0]        discs_fired
);

    cfg_t                      cfg;
    logic                      in_valid_reg, in_valid_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      level_reg;
    logic                      shooter_reg;
    logic signed [DRIVE_W-1:0] cmd_reg;
    logic                      in_accept;
    logic                      step;
    phase_t                    phase_core;

    fdr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: core steps when a word is held and the result slot frees up
    assign step      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !step;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input word register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            level_reg   <= switch_level;
            shooter_reg <= shooter_running;
            cmd_reg     <= drive_command;
        end
    end

    fdr_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .step            (step),
        .switch_level    (level_reg),
        .shooter_running (shooter_reg),
        .drive_command   (cmd_reg),
        .motor_drive     (motor_drive),
        .phase           (phase_core),
        .discs_fired     (discs_fired)
    );

    assign phase     = phase_core;
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/fdr_regs.sv
// APB-style configuration registers of the feeder roller sequencer.
// Depends on fdr_pkg for the register indexes and the cfg_t struct.
module fdr_regs
    import fdr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SWITCH_PRESENT: cfg_reg.switch_present     <= pwdata[0];
                REG_TRIGGER_WAIT:   cfg_reg.trigger_wait_ticks <= pwdata[WIN_W-1:0];
                REG_DEBOUNCE_IN:    cfg_reg.debounce_in_ticks  <= pwdata[WIN_W-1:0];
                REG_DEBOUNCE_OUT:   cfg_reg.debounce_out_ticks <= pwdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_SWITCH_PRESENT: prdata = DATA_W'(cfg_reg.switch_present);
            REG_TRIGGER_WAIT:   prdata = DATA_W'(cfg_reg.trigger_wait_ticks);
            REG_DEBOUNCE_IN:    prdata = DATA_W'(cfg_reg.debounce_in_ticks);
            REG_DEBOUNCE_OUT:   prdata = DATA_W'(cfg_reg.debounce_out_ticks);
            default:            prdata = '0;
        endcase
    end

endmodule

FILE: rtl/fdr_core.sv
// Phase sequencer, switch stretch and drive scaling; holds the result word.
// Depends on fdr_pkg for phase_t, cfg_t and the scale constants.
module fdr_core
    import fdr_pkg::*;
#(
    parameter int TIME_BITS = 20
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      step,
    input  logic                      switch_level,
    input  logic                      shooter_running,
    input  logic signed [DRIVE_W-1:0] drive_command,
    output logic signed [DRIVE_W-1:0] motor_drive,
    output phase_t                    phase,
    output logic [COUNT_W-1:0]        discs_fired
);

    localparam int CMP_W = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    phase_t                      phase_reg, phase_next;
    logic signed [DRIVE_W-1:0]   last_drive_reg, last_drive_next;
    logic [TIME_BITS-1:0]        ssp_reg, ssp_next;
    logic [TIME_BITS-1:0]        sdf_reg, sdf_next;
    logic [WIN_W-1:0]            window_reg, window_next;
    logic [COUNT_W-1:0]          fired_total_reg, fired_total_next;

    logic [TIME_BITS-1:0]        ssp_inc, sdf_inc, ssp_sampled;
    logic [WIN_W-1:0]            win_sel;
    logic                        pressed;
    logic                        wait_done;
    logic signed [31:0]          fifth_prod;
    logic signed [DRIVE_W-1:0]   fifth_drive;

    // Saturating elapsed counters
    assign ssp_inc = (ssp_reg == TIME_MAX) ? ssp_reg : TIME_BITS'(ssp_reg + 1'b1);
    assign sdf_inc = (sdf_reg == TIME_MAX) ? sdf_reg : TIME_BITS'(sdf_reg + 1'b1);

    // Stretched switch: start tick loads the in-window before sampling
    assign win_sel     = (phase_reg == PH_START) ? cfg.debounce_in_ticks : window_reg;
    assign pressed     = !switch_level || (CMP_W'(ssp_inc) <= CMP_W'(win_sel));
    assign ssp_sampled = switch_level ? ssp_inc : '0;
    assign wait_done   = CMP_W'(sdf_inc) > CMP_W'(cfg.trigger_wait_ticks);

    // 0.2 scale, floor via arithmetic shift
    assign fifth_prod  = 32'(drive_command) * FIFTH_MULT;
    assign fifth_drive = fifth_prod[FIFTH_SHIFT +: DRIVE_W];

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (cfg.switch_present)
        begin
            unique case (phase_reg)
                PH_START:
                    phase_next = pressed ? PH_FIRING : PH_STAGING;
                PH_STAGING:
                    if (pressed && last_drive_reg != '0)
                        phase_next = PH_FIRING;
                PH_FIRING:
                    if (shooter_running && !pressed)
                        phase_next = PH_FIRED;
                PH_FIRED:
                    phase_next = PH_STAGING;
                default:
                    phase_next = PH_START;
            endcase
        end
    end

    // Drive, window and counter updates
    always_comb
    begin
        last_drive_next  = last_drive_reg;
        ssp_next         = ssp_inc;
        sdf_next         = sdf_inc;
        window_next      = window_reg;
        fired_total_next = fired_total_reg;
        if (!cfg.switch_present)
        begin
            last_drive_next = drive_command;
        end
        else
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    window_next = cfg.debounce_in_ticks;
                    ssp_next    = ssp_sampled;
                end
                PH_STAGING:
                begin
                    ssp_next = ssp_sampled;
                    if (pressed && last_drive_reg != '0)
                    begin
                        last_drive_next = '0;
                    end
                    else
                    begin
                        window_next     = cfg.debounce_in_ticks;
                        last_drive_next = fifth_drive;
                    end
                end
                PH_FIRING:
                begin
                    if (shooter_running)
                    begin
                        ssp_next = ssp_sampled;
                        if (!pressed)
                        begin
                            last_drive_next = '0;
                        end
                        else if (wait_done)
                        begin
                            window_next     = cfg.debounce_out_ticks;
                            last_drive_next = drive_command;
                        end
                    end
                end
                PH_FIRED:
                begin
                    ssp_next         = TIME_MAX;
                    sdf_next         = '0;
                    fired_total_next = COUNT_W'(fired_total_reg + 1'b1);
                end
                default: ;
            endcase
        end
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            last_drive_reg  <= '0;
            ssp_reg         <= TIME_MAX;
            sdf_reg         <= '0;
            window_reg      <= '0;
            fired_total_reg <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            last_drive_reg  <= last_drive_next;
            ssp_reg         <= ssp_next;
            sdf_reg         <= sdf_next;
            window_reg      <= window_next;
            fired_total_reg <= fired_total_next;
        end
    end

    assign motor_drive = last_drive_reg;
    assign phase       = phase_reg;
    assign discs_fired = fired_total_reg;

    // Without a switch the phase never moves
    a_no_switch_hold: assert property (@(posedge clk) disable iff (!rst_n)
        step && !cfg.switch_present |=> $stable(phase_reg))
        else $error("phase moved with no switch fitted");

    // A fired tick returns to staging and restarts the trigger wait
    a_fired_return: assert property (@(posedge clk) disable iff (!rst_n)
        step && cfg.switch_present && phase_reg == PH_FIRED
        |=> phase_reg == PH_STAGING && sdf_reg == '0)
        else $error("fired tick did not return to staging");

    // Disc count only moves on a fired tick
    a_count_only_fired: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && cfg.switch_present && phase_reg == PH_FIRED)
        |=> $stable(fired_total_reg))
        else $error("disc count changed outside a fired tick");

endmodule

FILE: dv/tb_feeder_roller_sequencer.sv
// Testbench for feeder_roller_sequencer: random and directed drive words, APB setup.
// Holds its own scoreboard class that predicts each tick. Needs fdr_pkg and the RTL.
`timescale 1ns / 1ps

import fdr_pkg::*;

// Scoreboard: tracks the sequencer state and the expected motor words
class RollerScoreboard;
    localparam int TB_TIME_W = 20;
    localparam logic [TB_TIME_W-1:0] TICKS_SAT = {TB_TIME_W{1'b1}};

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        phase_t                    ph;
        logic [COUNT_W-1:0]        count;
    } roller_word_t;

    // register copy
    bit                    sw_fitted;
    logic [WIN_W-1:0]      trig_wait;
    logic [WIN_W-1:0]      win_in;
    logic [WIN_W-1:0]      win_out;

    // sequencer state
    phase_t                    cur_phase;
    logic signed [DRIVE_W-1:0] prev_drive;
    logic [TB_TIME_W-1:0]      since_press;
    logic [TB_TIME_W-1:0]      since_fire;
    logic [WIN_W-1:0]          hold_window;
    logic [COUNT_W-1:0]        disc_count;

    roller_word_t expected_drives[$];
    int           mismatches;

    function new();
        sw_fitted   = 1'b0;
        trig_wait   = '0;
        win_in      = '0;
        win_out     = '0;
        cur_phase   = PH_START;
        prev_drive  = '0;
        since_press = TICKS_SAT;
        since_fire  = '0;
        hold_window = '0;
        disc_count  = '0;
        mismatches  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
        case (idx)
            REG_SWITCH_PRESENT: sw_fitted = value[0];
            REG_TRIGGER_WAIT:   trig_wait = value[WIN_W-1:0];
            REG_DEBOUNCE_IN:    win_in    = value[WIN_W-1:0];
            REG_DEBOUNCE_OUT:   win_out   = value[WIN_W-1:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_drives.size();
    endfunction

    // Stretched switch: a press restarts the counter, a release reads pressed
    // while the counter is still inside the hold window.
    function bit switch_held(bit level);
        if (level)
            return since_press <= hold_window;
        since_press = '0;
        return 1'b1;
    endfunction

    // 0.2 scale, arithmetic shift rounds toward minus infinity
    function logic signed [DRIVE_W-1:0] fifth_of(logic signed [DRIVE_W-1:0] cmd);
        logic signed [31:0] prod;
        prod = cmd * FIFTH_MULT;
        prod = prod >>> FIFTH_SHIFT;
        return prod[DRIVE_W-1:0];
    endfunction

    // One accepted tick: advance the state and queue the word it yields
    function void note_word(bit level, bit shooter, logic signed [DRIVE_W-1:0] cmd);
        logic signed [DRIVE_W-1:0] drive;
        roller_word_t              res;
        drive = prev_drive;
        if (since_press != TICKS_SAT)
            since_press++;
        if (since_fire != TICKS_SAT)
            since_fire++;

        if (!sw_fitted)
            drive = cmd;
        else
        begin
            case (cur_phase)
                PH_START:
                begin
                    hold_window = win_in;
                    cur_phase = switch_held(level) ? PH_FIRING : PH_STAGING;
                end
                PH_STAGING:
                begin
                    // sample first: the press side effect always happens
                    if (switch_held(level) && prev_drive != 0)
                    begin
                        cur_phase = PH_FIRING;
                        drive = '0;
                    end
                    else
                    begin
                        hold_window = win_in;
                        drive = fifth_of(cmd);
                    end
                end
                PH_FIRING:
                begin
                    if (shooter)
                    begin
                        if (!switch_held(level))
                        begin
                            cur_phase = PH_FIRED;
                            drive = '0;
                        end
                        else if (since_fire > TB_TIME_W'(trig_wait))
                        begin
                            hold_window = win_out;
                            drive = cmd;
                        end
                    end
                end
                default:
                begin
                    since_press = TICKS_SAT;
                    since_fire  = '0;
                    cur_phase   = PH_STAGING;
                    disc_count++;
                end
            endcase
        end

        prev_drive = drive;
        res.drive = drive;
        res.ph    = cur_phase;
        res.count = disc_count;
        expected_drives.push_back(res);
    endfunction

    function void check_word(logic signed [DRIVE_W-1:0] drive, logic [1:0] ph,
                             logic [COUNT_W-1:0] count);
        roller_word_t exp_w;
        if (expected_drives.size() == 0)
        begin
            $error("motor word with none expected: drive %0d phase %0d discs %0d",
                   drive, ph, count);
            mismatches++;
            return;
        end
        exp_w = expected_drives.pop_front();
        if (drive !== exp_w.drive)
        begin
            $error("motor_drive expected %0d actual %0d", exp_w.drive, drive);
            mismatches++;
        end
        if (ph !== exp_w.ph)
        begin
            $error("phase expected %0d actual %0d", exp_w.ph, ph);
            mismatches++;
        end
        if (count !== exp_w.count)
        begin
            $error("discs_fired expected %0d actual %0d", exp_w.count, count);
            mismatches++;
        end
    endfunction
endclass

module tb_feeder_roller_sequencer;
    localparam int TIME_W       = 20;
    localparam int LATENCY_PAD  = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int WORDS_PER_PH = 100;
    localparam int NUM_SETTINGS = 10;
    localparam logic [WIN_W-1:0] WIN_MAX = {WIN_W{1'b1}};

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      in_valid;
    logic                      in_stall;
    logic                      switch_level;
    logic                      shooter_running;
    logic signed [DRIVE_W-1:0] drive_command;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [DRIVE_W-1:0] motor_drive;
    logic [1:0]                phase;
    logic [COUNT_W-1:0]        discs_fired;

    RollerScoreboard sb;
    bit              calm;
    int              stall_left;
    int              cycle_count;
    bit              sw_level_now;
    int              sw_run_left;

    feeder_roller_sequencer #(.TIME_BITS(TIME_W)) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .switch_level    (switch_level),
        .shooter_running (shooter_running),
        .drive_command   (drive_command),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .motor_drive     (motor_drive),
        .phase           (phase),
        .discs_fired     (discs_fired)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Mostly short gaps, a few long ones, none while calm
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (rst_n && !calm && $urandom_range(0, 99) < 15)
        begin
            out_stall <= 1'b1;
            stall_left = pick_gap();
        end
        else
            out_stall <= 1'b0;
    end

    // Result check on every accepted word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(motor_drive, phase, discs_fired);
    end

    // Run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Present one word and hold it until accepted
    task automatic send_word(input bit level, input bit shooter,
                             input logic signed [DRIVE_W-1:0] cmd);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        switch_level    <= level;
        shooter_running <= shooter;
        drive_command   <= cmd;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        sb.note_word(level, shooter, cmd);
    endtask

    // APB write; psel stays up so back-to-back writes chain
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, value);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // New setting, only once the block has gone idle; junk in the unused high bits
    task automatic apply_setting(input bit fitted, input logic [WIN_W-1:0] trig,
                                 input logic [WIN_W-1:0] w_in,
                                 input logic [WIN_W-1:0] w_out);
        in_valid <= 1'b0;
        wait_drained();
        repeat (LATENCY_PAD) @(posedge clk);
        reg_write(REG_SWITCH_PRESENT, {31'($urandom), fitted});
        reg_write(REG_TRIGGER_WAIT, {12'($urandom), trig});
        reg_write(REG_DEBOUNCE_IN, {12'($urandom), w_in});
        reg_write(REG_DEBOUNCE_OUT, {12'($urandom), w_out});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random word: switch levels come in runs like a disc passing,
    // with the odd single-tick glitch
    task automatic send_random_word();
        bit                        level;
        logic signed [DRIVE_W-1:0] cmd;
        int                        r;
        if (sw_run_left == 0)
        begin
            sw_level_now = !sw_level_now;
            sw_run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(1, 8);
        end
        sw_run_left--;
        level = sw_level_now;
        if ($urandom_range(0, 9) == 0)
            level = !level;
        r = $urandom_range(0, 9);
        if (r == 0)
            cmd = '0;
        else if (r == 1)
            cmd = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        else
            cmd = DRIVE_W'($urandom);
        send_word(level, $urandom_range(0, 99) < 85, cmd);
    endtask

    initial
    begin
        sb              = new();
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_valid        = 1'b0;
        switch_level    = 1'b1;
        shooter_running = 1'b0;
        drive_command   = '0;
        out_stall       = 1'b0;
        stall_left      = 0;
        cycle_count     = 0;
        calm            = 1'b0;
        sw_level_now    = 1'b1;
        sw_run_left     = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No switch fitted: command goes straight through, phase stays at start
        send_word(1'b1, 1'b0, 16'sh0000);
        send_word(1'b0, 1'b1, 16'sh7FFF);
        send_word(1'b1, 1'b1, 16'sh8000);
        send_word(1'b0, 1'b0, -16'sd1);
        send_word(1'b1, 1'b1, 16'sd1);
        send_word(1'b0, 1'b1, 16'sh5555);
        send_word(1'b1, 1'b0, 16'shAAAA);

        // Switch fitted, zero windows: walk a full disc cycle by hand
        apply_setting(1'b1, 20'd6, 20'd0, 20'd0);
        send_word(1'b1, 1'b1, 16'sd0);        // start tick, released -> staging
        send_word(1'b1, 1'b1, 16'sd0);        // staging, zero drive
        send_word(1'b0, 1'b1, 16'sh8000);     // pressed but last drive zero
        send_word(1'b1, 1'b0, 16'sh7FFF);     // released past window
        send_word(1'b0, 1'b1, 16'sd1);        // staging exit -> firing
        send_word(1'b1, 1'b0, 16'sd500);      // firing, shooter stopped
        send_word(1'b0, 1'b1, -16'sd1000);    // trigger wait long passed: full drive
        send_word(1'b1, 1'b1, 16'sd77);       // released -> fired
        send_word(1'b1, 1'b1, 16'sd77);       // fired tick, count one disc
        send_word(1'b0, 1'b1, 16'sd4);        // fifth of 4 is zero
        send_word(1'b0, 1'b1, -16'sd5);       // fifth of -5 rounds down to -1
        send_word(1'b0, 1'b1, 16'sd9);        // staging exit
        send_word(1'b0, 1'b1, 16'sd1234);     // inside trigger wait: hold
        send_word(1'b0, 1'b1, 16'sd2222);
        send_word(1'b0, 1'b1, 16'sd3333);     // equal to wait: still hold
        send_word(1'b0, 1'b1, 16'sd4444);     // past wait: full drive
        send_word(1'b1, 1'b1, 16'sd0);        // released -> fired
        send_word(1'b0, 1'b0, 16'sd0);        // fired tick

        // Settings sweep: widest windows first (released keeps reading pressed), then
        // zero windows, the rest small windows for deep cycling but for one switchless stretch
        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            int n_words;
            n_words = WORDS_PER_PH;
            if (s == 0)
            begin
                apply_setting(1'b1, WIN_MAX, WIN_MAX, WIN_MAX);
                n_words = 30;
            end
            else if (s == 1)
                apply_setting(1'b1, '0, '0, '0);
            else if (s == 4)
                apply_setting(1'b0, WIN_W'($urandom_range(0, 12)),
                              WIN_W'($urandom_range(0, 6)), WIN_W'($urandom_range(0, 6)));
            else
                apply_setting(1'b1, WIN_W'($urandom_range(0, 12)),
                              WIN_W'($urandom_range(0, 6)), WIN_W'($urandom_range(0, 6)));
            for (int i = 0; i < n_words; i++)
            begin
                calm = ((i / 40) % 3) == 2;
                send_random_word();
            end
            calm = 1'b0;
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: feeder_roller_sequencer.f
rtl/fdr_pkg.sv
rtl/fdr_regs.sv
rtl/fdr_core.sv
rtl/feeder_roller_sequencer.sv
dv/tb_feeder_roller_sequencer.sv
